// ===== hdl/broadcast_ring_multi_reader_top_assert.svh =====
// Assertion macros for the broadcast ring checker
`ifndef BROADCAST_RING_MULTI_READER_TOP_ASSERT_SVH
`define BROADCAST_RING_MULTI_READER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BRMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BRMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/brmr_pkg.sv =====
// Shared types, constants and helpers for the broadcast ring
`default_nettype none

package brmr_pkg;

    localparam int RING_DEPTH   = 16;
    localparam int READER_SLOTS = 8;
    localparam int WORD_BITS    = 32;

    localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int SLOT_W  = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
    localparam int TOTAL_W = $clog2(READER_SLOTS + 1);
    localparam int ID_W    = 4;
    localparam int DATA_W  = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_ADD    = 2'd2
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic             go;
        op_t              op;
        logic [ID_W-1:0]  rid;
        logic [PTR_W-1:0] wr_pos;
    } req_t;

    typedef struct packed {
        logic             rd_hit;
        logic [PTR_W-1:0] rd_addr;
        logic [1:0]       status;
        logic [ID_W-1:0]  new_id;
        logic             ovw;
    } resp_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(RING_DEPTH - 1))
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/broadcast_ring_multi_reader_top.sv =====
// Top level of the multi-reader broadcast ring
//
// Input channel: in_valid / in_stall with opcode, payload, reader_num.
// An item is taken at a clock edge with in_valid high and in_stall low.
// Opcodes: insert a word, read the next word for a reader, add a reader.
// Output channel: out_valid / out_stall with read_data, status,
// new_reader_id, overwrite; exactly one result item per input item.
// The result passes through pend_reg and the registered ring read, then
// into the output register once it is free. One item is worked at a time;
// the block takes no new item while busy, until its result is loaded.
// The output register lets the next item be taken while a result waits.
// When out_stall holds, the result stays put; once the item behind it is
// taken, in_stall stays high until the output register frees.
// Reset clears the write position, reader count, reader positions and
// unread counts; no clearing pass runs, ring entries are valid once written.
// A read with an unknown id or nothing waiting gives status empty; an add
// with all reader slots taken gives status full and changes nothing.
`default_nettype none

module broadcast_ring_multi_reader_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] payload,
    input  wire logic [3:0]  reader_num,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      read_data,
    output logic [1:0]       status,
    output logic [3:0]       new_reader_id,
    output logic             overwrite
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [brmr_pkg::PTR_W-1:0]      write_position_reg;
    logic [brmr_pkg::PTR_W-1:0]      write_position_next;
    brmr_pkg::resp_t                 pend_reg;
    brmr_pkg::req_t                  req;
    brmr_pkg::resp_t                 resp;
    logic [brmr_pkg::WORD_BITS-1:0]  mem_rdata;

    logic                            in_acc;
    logic                            out_free;
    logic                            out_load;
    logic                            mem_we;
    logic                            mem_re;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [31:0]                     read_data_reg;
    logic [1:0]                      status_reg;
    logic [3:0]                      new_reader_id_reg;
    logic                            overwrite_reg;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_BUSY) && out_free;

    assign req.go     = in_acc;
    assign req.op     = brmr_pkg::op_t'(opcode);
    assign req.rid    = reader_num;
    assign req.wr_pos = write_position_reg;

    assign mem_we = in_acc && (req.op == brmr_pkg::OP_INSERT);
    assign mem_re = in_acc && resp.rd_hit;

    brmr_reader_bank u_readers (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .resp  (resp)
    );

    brmr_ring_ram u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (write_position_reg),
        .wdata (brmr_pkg::WORD_BITS'(payload)),
        .re    (mem_re),
        .raddr (resp.rd_addr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        write_position_next = write_position_reg;
        if (mem_we)
        begin
            write_position_next = brmr_pkg::ring_next(write_position_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            write_position_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            write_position_reg <= write_position_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pend_reg <= resp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_data_reg     <= pend_reg.rd_hit ? brmr_pkg::DATA_W'(mem_rdata) : '0;
            status_reg        <= pend_reg.status;
            new_reader_id_reg <= pend_reg.new_id;
            overwrite_reg     <= pend_reg.ovw;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign status        = status_reg;
    assign new_reader_id = new_reader_id_reg;
    assign overwrite     = overwrite_reg;

endmodule

`default_nettype wire

// ===== hdl/brmr_ring_ram.sv =====
// Message ring storage: one write port, one registered read port
`default_nettype none

module brmr_ring_ram (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [brmr_pkg::PTR_W-1:0]     waddr,
    input  wire logic [brmr_pkg::WORD_BITS-1:0] wdata,
    input  wire logic                           re,
    input  wire logic [brmr_pkg::PTR_W-1:0]     raddr,
    output logic      [brmr_pkg::WORD_BITS-1:0] rdata
);

    logic [brmr_pkg::WORD_BITS-1:0] mem [brmr_pkg::RING_DEPTH];
    logic [brmr_pkg::WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/brmr_reader_bank.sv =====
// Per-reader positions and unread counts, updated in parallel per item
`default_nettype none

module brmr_reader_bank (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire brmr_pkg::req_t  req,
    output brmr_pkg::resp_t      resp
);

    logic [brmr_pkg::PTR_W-1:0]   pos_reg    [brmr_pkg::READER_SLOTS];
    logic [brmr_pkg::PTR_W-1:0]   pos_next   [brmr_pkg::READER_SLOTS];
    logic [brmr_pkg::CNT_W-1:0]   unread_reg [brmr_pkg::READER_SLOTS];
    logic [brmr_pkg::CNT_W-1:0]   unread_next[brmr_pkg::READER_SLOTS];
    logic [brmr_pkg::TOTAL_W-1:0] total_reg;
    logic [brmr_pkg::TOTAL_W-1:0] total_next;

    logic                         rid_ok;
    logic [brmr_pkg::ID_W-1:0]    rid_m1;
    logic [brmr_pkg::SLOT_W-1:0]  rslot;
    logic [brmr_pkg::SLOT_W-1:0]  tslot;

    assign rid_ok = (req.rid != '0) &&
                    (req.rid <= brmr_pkg::ID_W'(total_reg));
    assign rid_m1 = req.rid - brmr_pkg::ID_W'(1);
    assign rslot  = rid_m1[brmr_pkg::SLOT_W-1:0];
    assign tslot  = total_reg[brmr_pkg::SLOT_W-1:0];

    always_comb
    begin
        pos_next    = pos_reg;
        unread_next = unread_reg;
        total_next  = total_reg;
        resp        = '0;
        case (req.op)
            brmr_pkg::OP_INSERT:
            begin
                for (int i = 0; i < brmr_pkg::READER_SLOTS; i++)
                begin
                    if (brmr_pkg::TOTAL_W'(i) < total_reg)
                    begin
                        if (unread_reg[i] == brmr_pkg::CNT_W'(brmr_pkg::RING_DEPTH))
                        begin
                            pos_next[i] = brmr_pkg::ring_next(pos_reg[i]);
                            resp.ovw    = 1'b1;
                        end
                        else
                        begin
                            unread_next[i] = unread_reg[i] + brmr_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            brmr_pkg::OP_READ:
            begin
                resp.rd_addr = pos_reg[rslot];
                if (rid_ok && (unread_reg[rslot] != '0))
                begin
                    resp.rd_hit        = 1'b1;
                    pos_next[rslot]    = brmr_pkg::ring_next(pos_reg[rslot]);
                    unread_next[rslot] = unread_reg[rslot] - brmr_pkg::CNT_W'(1);
                end
                else
                begin
                    resp.status = brmr_pkg::ST_EMPTY;
                end
            end
            brmr_pkg::OP_ADD:
            begin
                if (total_reg == brmr_pkg::TOTAL_W'(brmr_pkg::READER_SLOTS))
                begin
                    resp.status = brmr_pkg::ST_FULL;
                end
                else
                begin
                    pos_next[tslot]    = req.wr_pos;
                    unread_next[tslot] = '0;
                    total_next         = total_reg + brmr_pkg::TOTAL_W'(1);
                    resp.new_id        = brmr_pkg::ID_W'(total_next);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < brmr_pkg::READER_SLOTS; i++)
            begin
                pos_reg[i]    <= '0;
                unread_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (req.go)
        begin
            pos_reg    <= pos_next;
            unread_reg <= unread_next;
            total_reg  <= total_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/brmr_checker.sv =====
// Port-level checker for the broadcast ring, bound to the top level
`default_nettype none

`include "broadcast_ring_multi_reader_top_assert.svh"

module brmr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] read_data,
    input wire logic [1:0]  status,
    input wire logic [3:0]  new_reader_id,
    input wire logic        overwrite
);

    logic        bad_status;
    logic        err_clear;
    logic        new_id_out;
    logic        add_clear;
    logic        out_wait;
    logic [38:0] out_word;

    assign bad_status = (status != brmr_pkg::ST_OK);
    assign err_clear  = (read_data == 32'd0) && (new_reader_id == 4'd0) && !overwrite;
    assign new_id_out = (new_reader_id != 4'd0);
    assign add_clear  = (status == brmr_pkg::ST_OK) && (read_data == 32'd0) && !overwrite;
    assign out_wait   = out_valid && out_stall;
    assign out_word   = {read_data, status, new_reader_id, overwrite};

    `BRMR_ASSERT_NEXT(a_one_item_at_a_time, in_valid && !in_stall, in_stall, "item overlap")

    `BRMR_ASSERT_NOW(a_error_fields_clear, out_valid && bad_status, err_clear, "bad error item")

    `BRMR_ASSERT_NOW(a_new_id_alone, out_valid && new_id_out, add_clear, "add result mixed")

    `BRMR_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_word), "item changed")

endmodule

bind broadcast_ring_multi_reader_top brmr_checker u_brmr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .status        (status),
    .new_reader_id (new_reader_id),
    .overwrite     (overwrite)
);

`default_nettype wire
